### hdl/smsl_pkg.sv
package smsl_pkg;

    // Default depth of the sorted window and of the arrival ring.
    localparam int unsigned WINDOW_MAX_DEF = 1024;

    // Register indexes on the configuration port.
    localparam logic [2:0] REG_WINDOW_LEN    = 3'd0;
    localparam logic [2:0] REG_GROWTH_FACTOR = 3'd1;
    localparam logic [2:0] REG_BASE_LIMIT    = 3'd2;
    localparam logic [2:0] REG_CEILING_LIMIT = 3'd3;
    localparam logic [2:0] REG_FORK_HEIGHT   = 3'd4;

    // Reset values of the configuration registers.
    localparam logic [10:0] WINDOW_LEN_RST    = 11'd1024;
    localparam logic [7:0]  GROWTH_FACTOR_RST = 8'd2;
    localparam logic [30:0] BASE_LIMIT_RST    = 31'd1000000;
    localparam logic [31:0] CEILING_LIMIT_RST = 32'd32000000;
    localparam logic [30:0] FORK_HEIGHT_RST   = 31'd0;

    typedef struct packed {
        logic [30:0] height;
        logic [31:0] item_size;
    } smsl_in_t;

    typedef struct packed {
        logic [31:0] size_limit;
        logic        window_full;
        logic        repeated;
    } smsl_out_t;

    typedef struct packed {
        logic [10:0] window_len;
        logic [7:0]  growth_factor;
        logic [30:0] base_limit;
        logic [31:0] ceiling_limit;
        logic [30:0] fork_height;
    } smsl_cfg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DROP_CHK,
        ST_DROP_RING,
        ST_DROP_SCAN,
        ST_INS_START,
        ST_INS_SCAN,
        ST_INS_LAST,
        ST_MED_A,
        ST_MED_B,
        ST_MED_C,
        ST_MUL,
        ST_FLOOR,
        ST_WRAP
    } smsl_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic check;
        logic drop_chk;
        logic drop_start;
        logic drop_step;
        logic ins_start;
        logic ins_step;
        logic ins_last;
        logic med_a;
        logic med_b;
        logic med_c;
        logic mul;
        logic floor_res;
        logic finish;
    } smsl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic height_eq;
        logic need_drop;
        logic drop_last;
        logic fill_zero;
        logic ins_hit;
        logic k_zero;
        logic len_full;
        logic len_even;
        logic out_free;
    } smsl_sts_t;

endpackage

### hdl/sliding_median_size_limit_core.sv
// Running median size limit.
// Input channel (item_valid, item_stall, item): one item per height with its
// size. Result channel (res_valid, res_stall, res): exactly one result item
// per input item, in order. Configuration is written over the APB port; the
// user must write it only while the block is idle, which the block itself
// does not enforce. Registers lie at byte addresses 0, 4, 8, 12 and 16.
// One item is worked on at a time. A repeated height goes from the check
// straight to the output load. Otherwise the item walks the sorted window
// memory once per removal to drop the oldest size and once to insert the new
// size, then, at a full window, takes the median and the scaling, then the
// clamps and the output load. The walks go through the sorted window memory
// one entry per cycle. A finished result waits in an output register; the
// next item is taken while it waits, and the block holds in its last step
// only if a second result is ready while the first is still stalled.
// Reset empties the window and the result cache and loads the register
// defaults; the window memories themselves are not cleared.
module sliding_median_size_limit_core
    import smsl_pkg::*;
#(
    parameter int unsigned WINDOW_MAX = WINDOW_MAX_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_stall,
    input  smsl_in_t    item,
    output logic        res_valid,
    input  logic        res_stall,
    output smsl_out_t   res,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    smsl_cfg_t cfg_reg;
    smsl_cmd_t cmd;
    smsl_sts_t sts;
    logic      cfg_wr;
    logic [2:0] reg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign reg_idx = paddr[4:2];

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.window_len    <= WINDOW_LEN_RST;
            cfg_reg.growth_factor <= GROWTH_FACTOR_RST;
            cfg_reg.base_limit    <= BASE_LIMIT_RST;
            cfg_reg.ceiling_limit <= CEILING_LIMIT_RST;
            cfg_reg.fork_height   <= FORK_HEIGHT_RST;
        end
        else if (cfg_wr)
        begin
            case (reg_idx)
                REG_WINDOW_LEN:    cfg_reg.window_len    <= pwdata[10:0];
                REG_GROWTH_FACTOR: cfg_reg.growth_factor <= pwdata[7:0];
                REG_BASE_LIMIT:    cfg_reg.base_limit    <= pwdata[30:0];
                REG_CEILING_LIMIT: cfg_reg.ceiling_limit <= pwdata;
                REG_FORK_HEIGHT:   cfg_reg.fork_height   <= pwdata[30:0];
                default:           ;
            endcase
        end
    end

    // Register read decoder.
    always_comb
    begin
        unique case (reg_idx)
            REG_WINDOW_LEN:    prdata = {21'd0, cfg_reg.window_len};
            REG_GROWTH_FACTOR: prdata = {24'd0, cfg_reg.growth_factor};
            REG_BASE_LIMIT:    prdata = {1'b0, cfg_reg.base_limit};
            REG_CEILING_LIMIT: prdata = cfg_reg.ceiling_limit;
            REG_FORK_HEIGHT:   prdata = {1'b0, cfg_reg.fork_height};
            default:           prdata = '0;
        endcase
    end

    smsl_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .sts        (sts),
        .cmd        (cmd)
    );

    smsl_dp #(
        .WINDOW_MAX (WINDOW_MAX)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .cfg       (cfg_reg),
        .cmd       (cmd),
        .sts       (sts),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

endmodule

### hdl/smsl_ctrl.sv
module smsl_ctrl
    import smsl_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      item_valid,
    output logic      item_stall,
    input  smsl_sts_t sts,
    output smsl_cmd_t cmd
);

    smsl_state_t state_reg;
    smsl_state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        item_stall = (state_reg != ST_IDLE);
        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                cmd.check  = 1'b1;
                state_next = sts.height_eq ? ST_WRAP : ST_DROP_CHK;
            end
            ST_DROP_CHK:
            begin
                cmd.drop_chk = 1'b1;
                state_next   = sts.need_drop ? ST_DROP_RING : ST_INS_START;
            end
            ST_DROP_RING:
            begin
                cmd.drop_start = 1'b1;
                state_next     = ST_DROP_SCAN;
            end
            ST_DROP_SCAN:
            begin
                cmd.drop_step = 1'b1;
                if (sts.drop_last)
                begin
                    state_next = ST_DROP_CHK;
                end
            end
            ST_INS_START:
            begin
                cmd.ins_start = 1'b1;
                state_next    = sts.fill_zero ? ST_MED_A : ST_INS_SCAN;
            end
            ST_INS_SCAN:
            begin
                cmd.ins_step = 1'b1;
                if (sts.ins_hit)
                begin
                    state_next = ST_MED_A;
                end
                else if (sts.k_zero)
                begin
                    state_next = ST_INS_LAST;
                end
            end
            ST_INS_LAST:
            begin
                cmd.ins_last = 1'b1;
                state_next   = ST_MED_A;
            end
            ST_MED_A:
            begin
                cmd.med_a  = 1'b1;
                state_next = sts.len_full ? ST_MED_B : ST_FLOOR;
            end
            ST_MED_B:
            begin
                cmd.med_b  = 1'b1;
                state_next = sts.len_even ? ST_MED_C : ST_MUL;
            end
            ST_MED_C:
            begin
                cmd.med_c  = 1'b1;
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_FLOOR;
            end
            ST_FLOOR:
            begin
                cmd.floor_res = 1'b1;
                state_next    = ST_WRAP;
            end
            ST_WRAP:
            begin
                cmd.finish = 1'b1;
                if (sts.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

### hdl/smsl_dp.sv
module smsl_dp
    import smsl_pkg::*;
#(
    parameter int unsigned WINDOW_MAX = WINDOW_MAX_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  smsl_in_t  item,
    input  smsl_cfg_t cfg,
    input  smsl_cmd_t cmd,
    output smsl_sts_t sts,
    output logic      res_valid,
    input  logic      res_stall,
    output smsl_out_t res
);

    localparam int unsigned IDX_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int unsigned CNT_W = $clog2(WINDOW_MAX + 1);

    // Window memories.
    logic [31:0] sorted_mem [0:WINDOW_MAX-1];
    logic [31:0] ring_mem   [0:WINDOW_MAX-1];

    logic             sw_we;
    logic [IDX_W-1:0] sw_waddr;
    logic [31:0]      sw_wdata;
    logic             sw_re;
    logic [IDX_W-1:0] sw_raddr;
    logic [31:0]      sw_rd_reg;
    logic             rg_we;
    logic [IDX_W-1:0] rg_waddr;
    logic             rg_re;
    logic [31:0]      rg_rd_reg;

    logic [30:0]      height_reg;
    logic [31:0]      size_reg;
    logic [CNT_W-1:0] fill_reg;
    logic [CNT_W-1:0] fill_next;
    logic [IDX_W-1:0] head_reg;
    logic [IDX_W-1:0] head_next;
    logic [IDX_W-1:0] k_reg;
    logic [IDX_W-1:0] k_next;
    logic             found_reg;
    logic             found_next;
    logic [30:0]      last_height_reg;
    logic [31:0]      last_result_reg;
    logic             full_reg;
    logic             rep_reg;
    logic [32:0]      sum_reg;
    logic [39:0]      prod_reg;
    logic [31:0]      res_reg;
    logic             out_valid_reg;
    smsl_out_t        out_data_reg;

    logic [CNT_W-1:0] len;
    logic [IDX_W-1:0] mid_idx;
    logic [CNT_W:0]   slot_sum;
    logic [IDX_W-1:0] slot;
    logic [IDX_W-1:0] head_inc;
    logic [31:0]      median;
    logic [31:0]      sat;
    logic [31:0]      base32;
    logic [31:0]      twice_base;
    logic [31:0]      forked;
    logic [31:0]      final_res;
    logic             out_free;
    logic             load_out;

    // Effective window length: zero counts as one, clipped at the depth.
    always_comb
    begin
        if (cfg.window_len == '0)
        begin
            len = CNT_W'(1);
        end
        else if (32'(cfg.window_len) > 32'(WINDOW_MAX))
        begin
            len = CNT_W'(WINDOW_MAX);
        end
        else
        begin
            len = CNT_W'(cfg.window_len);
        end
    end

    assign mid_idx = IDX_W'(len >> 1);

    // Ring slot of the newest entry and the next head position.
    always_comb
    begin
        slot_sum = (CNT_W + 1)'(head_reg) + (CNT_W + 1)'(fill_reg);
        if (slot_sum >= (CNT_W + 1)'(WINDOW_MAX))
        begin
            slot_sum = slot_sum - (CNT_W + 1)'(WINDOW_MAX);
        end
        slot = IDX_W'(slot_sum);
        if ((CNT_W'(head_reg) + CNT_W'(1)) == CNT_W'(WINDOW_MAX))
        begin
            head_inc = '0;
        end
        else
        begin
            head_inc = head_reg + IDX_W'(1);
        end
    end

    // Status toward the controller.
    assign out_free      = !out_valid_reg || !res_stall;
    assign sts.height_eq = (height_reg == last_height_reg);
    assign sts.need_drop = (fill_reg >= len);
    assign sts.drop_last = ((CNT_W'(k_reg) + CNT_W'(1)) >= fill_reg);
    assign sts.fill_zero = (fill_reg == '0);
    assign sts.ins_hit   = (sw_rd_reg < size_reg);
    assign sts.k_zero    = (k_reg == '0);
    assign sts.len_full  = (fill_reg == len);
    assign sts.len_even  = !len[0];
    assign sts.out_free  = out_free;

    // Memory access and window bookkeeping for each command.
    always_comb
    begin
        sw_we      = 1'b0;
        sw_waddr   = '0;
        sw_wdata   = sw_rd_reg;
        sw_re      = 1'b0;
        sw_raddr   = '0;
        rg_we      = 1'b0;
        rg_waddr   = slot;
        rg_re      = 1'b0;
        fill_next  = fill_reg;
        head_next  = head_reg;
        k_next     = k_reg;
        found_next = found_reg;

        if (cmd.check && !sts.height_eq && (height_reg < last_height_reg))
        begin
            fill_next = '0;
            head_next = '0;
        end

        if (cmd.drop_chk)
        begin
            rg_re = 1'b1;
        end

        if (cmd.drop_start)
        begin
            sw_re      = 1'b1;
            sw_raddr   = '0;
            k_next     = '0;
            found_next = 1'b0;
        end

        // Remove the oldest entry: shift down everything above its match.
        if (cmd.drop_step)
        begin
            if (found_reg)
            begin
                sw_we    = 1'b1;
                sw_waddr = k_reg - IDX_W'(1);
            end
            else if (sw_rd_reg == rg_rd_reg)
            begin
                found_next = 1'b1;
            end
            if (!sts.drop_last)
            begin
                sw_re    = 1'b1;
                sw_raddr = k_reg + IDX_W'(1);
                k_next   = k_reg + IDX_W'(1);
            end
            else
            begin
                fill_next = fill_reg - CNT_W'(1);
                head_next = head_inc;
            end
        end

        if (cmd.ins_start)
        begin
            rg_we = 1'b1;
            if (fill_reg == '0)
            begin
                sw_we     = 1'b1;
                sw_waddr  = '0;
                sw_wdata  = size_reg;
                fill_next = CNT_W'(1);
            end
            else
            begin
                sw_re    = 1'b1;
                sw_raddr = IDX_W'(fill_reg - CNT_W'(1));
                k_next   = IDX_W'(fill_reg - CNT_W'(1));
            end
        end

        // Insert the newest entry: walk down, moving larger entries up one.
        if (cmd.ins_step)
        begin
            sw_we    = 1'b1;
            sw_waddr = k_reg + IDX_W'(1);
            if (sts.ins_hit)
            begin
                sw_wdata  = size_reg;
                fill_next = fill_reg + CNT_W'(1);
            end
            else if (!sts.k_zero)
            begin
                sw_re    = 1'b1;
                sw_raddr = k_reg - IDX_W'(1);
                k_next   = k_reg - IDX_W'(1);
            end
        end

        if (cmd.ins_last)
        begin
            sw_we     = 1'b1;
            sw_waddr  = '0;
            sw_wdata  = size_reg;
            fill_next = fill_reg + CNT_W'(1);
        end

        if (cmd.med_a)
        begin
            sw_re    = 1'b1;
            sw_raddr = mid_idx;
        end

        if (cmd.med_b && sts.len_even)
        begin
            sw_re    = 1'b1;
            sw_raddr = mid_idx - IDX_W'(1);
        end
    end

    // Sorted window memory.
    always_ff @(posedge clk)
    begin
        if (sw_we)
        begin
            sorted_mem[sw_waddr] <= sw_wdata;
        end
        if (sw_re)
        begin
            sw_rd_reg <= sorted_mem[sw_raddr];
        end
    end

    // Arrival ring memory.
    always_ff @(posedge clk)
    begin
        if (rg_we)
        begin
            ring_mem[rg_waddr] <= size_reg;
        end
        if (rg_re)
        begin
            rg_rd_reg <= ring_mem[head_reg];
        end
    end

    // Median, scaling with saturation and the clamps.
    assign median     = sts.len_even ? sum_reg[32:1] : sum_reg[31:0];
    assign sat        = (prod_reg[39:32] != '0) ? 32'hFFFF_FFFF : prod_reg[31:0];
    assign base32     = {1'b0, cfg.base_limit};
    assign twice_base = {cfg.base_limit, 1'b0};

    always_comb
    begin
        forked = res_reg;
        if ((height_reg >= cfg.fork_height) && (res_reg < twice_base))
        begin
            forked = twice_base;
        end
        if (rep_reg)
        begin
            final_res = last_result_reg;
        end
        else if (forked > cfg.ceiling_limit)
        begin
            final_res = cfg.ceiling_limit;
        end
        else
        begin
            final_res = forked;
        end
    end

    assign load_out = cmd.finish && out_free;

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            height_reg <= item.height;
            size_reg   <= item.item_size;
        end
        if (cmd.med_b)
        begin
            sum_reg <= {1'b0, sw_rd_reg};
        end
        if (cmd.med_c)
        begin
            sum_reg <= sum_reg + {1'b0, sw_rd_reg};
        end
        if (cmd.mul)
        begin
            prod_reg <= 40'(median) * 40'(cfg.growth_factor);
        end
        if (cmd.floor_res)
        begin
            if (full_reg)
            begin
                res_reg <= (sat < base32) ? base32 : sat;
            end
            else
            begin
                res_reg <= base32;
            end
        end
        if (load_out)
        begin
            out_data_reg.size_limit  <= final_res;
            out_data_reg.window_full <= full_reg;
            out_data_reg.repeated    <= rep_reg;
        end
    end

    // Control state of the window and the result cache.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg        <= '0;
            head_reg        <= '0;
            k_reg           <= '0;
            found_reg       <= 1'b0;
            last_height_reg <= '0;
            last_result_reg <= '0;
            full_reg        <= 1'b0;
            rep_reg         <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            fill_reg  <= fill_next;
            head_reg  <= head_next;
            k_reg     <= k_next;
            found_reg <= found_next;
            if (cmd.capture)
            begin
                full_reg <= 1'b0;
                rep_reg  <= 1'b0;
            end
            if (cmd.check && sts.height_eq)
            begin
                rep_reg <= 1'b1;
            end
            if (cmd.med_a)
            begin
                full_reg <= sts.len_full;
            end
            if (load_out && !rep_reg)
            begin
                last_height_reg <= height_reg;
                last_result_reg <= final_res;
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!res_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign res_valid = out_valid_reg;
    assign res       = out_data_reg;

endmodule
